FILE: sv/scfr_pkg.sv
// Package for the serial command frame receiver.
// Holds the result kind codes, register indexes, frame constants and the
// decoded command type. No dependencies.
package scfr_pkg;

  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned ADDR_W    = 10;

  localparam logic [ADDR_W-1:0] RGB_ADDR_MAX = 10'd510;
  localparam logic [ADDR_W-1:0] ONE_ADDR_MAX = 10'd512;

  localparam logic [7:0] STEP_RESET  = 8'd40;
  localparam logic [7:0] LIMIT_RESET = 8'd100;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_LRC_EN = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    KIND_GET_RGB = 3'd0,
    KIND_GET     = 3'd1,
    KIND_SET_RGB = 3'd2,
    KIND_SET     = 3'd3,
    KIND_ECHO    = 3'd4
  } kind_e;

  typedef struct packed {
    logic              echo;
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } cmd_t;

endpackage

FILE: sv/scfr_decode.sv
// Frame decoder: LRC sum and command decode of one complete 7-byte frame.
// Purely combinational. Depends on scfr_pkg.
module scfr_decode (
  input  logic [7:0]   frame_i [scfr_pkg::FRAME_LEN],
  output logic         lrc_zero_o,
  output scfr_pkg::cmd_t cmd_o
);

  logic [7:0]                  sum;
  logic                        set_bit;
  logic                        get_bit;
  logic [scfr_pkg::ADDR_W-1:0] from_addr;
  logic [scfr_pkg::ADDR_W-1:0] to_addr;
  logic                        bad;

  always_comb begin
    sum = '0;
    for (int i = 0; i < scfr_pkg::FRAME_LEN; i++) begin
      sum = sum + frame_i[i];
    end
  end

  assign lrc_zero_o = (sum == 8'd0);

  assign set_bit   = frame_i[0][0];
  assign get_bit   = frame_i[0][1];
  assign from_addr = {frame_i[1][5:0], frame_i[0][7:4]};
  assign to_addr   = {frame_i[2], frame_i[1][7:6]};

  always_comb begin
    if (to_addr == '0) begin
      bad = (from_addr == '0) || (from_addr > scfr_pkg::RGB_ADDR_MAX);
    end else begin
      bad = (from_addr != to_addr) || (from_addr == '0) ||
            (from_addr > scfr_pkg::ONE_ADDR_MAX);
    end
    if (!(set_bit ^ get_bit)) begin
      bad = 1'b1;
    end

    cmd_o.echo  = bad;
    cmd_o.kind  = scfr_pkg::KIND_ECHO;
    cmd_o.addr  = '0;
    cmd_o.red   = '0;
    cmd_o.green = '0;
    cmd_o.blue  = '0;
    if (!bad) begin
      cmd_o.addr = from_addr;
      if (to_addr == '0) begin
        if (get_bit) begin
          cmd_o.kind = scfr_pkg::KIND_GET_RGB;
        end else begin
          cmd_o.kind  = scfr_pkg::KIND_SET_RGB;
          cmd_o.red   = frame_i[3];
          cmd_o.green = frame_i[4];
          cmd_o.blue  = frame_i[5];
        end
      end else begin
        if (get_bit) begin
          cmd_o.kind = scfr_pkg::KIND_GET;
        end else begin
          cmd_o.kind = scfr_pkg::KIND_SET;
          cmd_o.red  = frame_i[3];
        end
      end
    end
  end

endmodule

FILE: sv/serial_command_frame_receiver_unit.sv
// Top level of the serial command frame receiver: config registers, frame
// assembly, idle timeout and the result buffer. Depends on scfr_pkg, scfr_decode.
//
// One input transaction (a received byte or a timer tick) is taken per cycle.
// The seventh byte of a frame is checked and decoded in the cycle it is
// accepted and, if the LRC sum is zero or the check is off, loads the result
// buffer, which then presents one command result, or seven echo results, one
// per cycle as the sink takes them; the first result is valid the cycle after
// the seventh byte is taken. While six bytes are held and the buffer still holds
// results of the previous frame, including the cycle in which its last result
// is taken, the input stalls, for bytes and ticks alike; the 6 bytes before it
// are taken freely meanwhile. Ticks never produce results.
module serial_command_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [9:0]  channel_address_o,
  output logic [7:0]  red_value_o,
  output logic [7:0]  green_value_o,
  output logic [7:0]  blue_value_o,
  output logic [7:0]  echo_byte_o,
  output logic        last_of_run_o
);

  localparam int unsigned STORE_N = scfr_pkg::FRAME_LEN - 1;

  // configuration
  logic       lrc_en_q;
  logic [7:0] step_q;
  logic [7:0] limit_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrc_en_q <= 1'b1;
      step_q   <= scfr_pkg::STEP_RESET;
      limit_q  <= scfr_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        scfr_pkg::REG_LRC_EN: lrc_en_q <= pwdata[0];
        scfr_pkg::REG_STEP:   step_q   <= pwdata[7:0];
        scfr_pkg::REG_LIMIT:  limit_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scfr_pkg::REG_LRC_EN: prdata = {31'd0, lrc_en_q};
      scfr_pkg::REG_STEP:   prdata = {24'd0, step_q};
      scfr_pkg::REG_LIMIT:  prdata = {24'd0, limit_q};
      default:              prdata = '0;
    endcase
  end

  // frame assembly
  logic [7:0]                 store_q [STORE_N];
  logic [scfr_pkg::CNT_W-1:0] byte_count_q, byte_count_d;
  logic [7:0]                 idle_q, idle_d;
  logic [7:0]                 idle_sum;
  logic                       in_acc;
  logic                       byte_acc;
  logic                       frame_done;
  logic [7:0]                 frame [scfr_pkg::FRAME_LEN];
  logic                       lrc_zero;
  scfr_pkg::cmd_t             cmd;
  logic                       load;

  // result buffer
  logic [2:0]                 left_q;
  scfr_pkg::kind_e            kind_q;
  logic [9:0]                 addr_q;
  logic [7:0]                 red_q, green_q, blue_q;
  logic [7:0]                 echo_q [scfr_pkg::FRAME_LEN];
  logic                       out_acc;

  assign out_valid_o = (left_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && (byte_count_q == scfr_pkg::LAST_IDX);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign byte_acc    = in_acc && !req_type_i;
  assign frame_done  = byte_acc && (byte_count_q == scfr_pkg::LAST_IDX);

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      frame[i] = store_q[i];
    end
    frame[scfr_pkg::FRAME_LEN-1] = rx_byte_i;
  end

  scfr_decode u_decode (
    .frame_i    (frame),
    .lrc_zero_o (lrc_zero),
    .cmd_o      (cmd)
  );

  assign load     = frame_done && (!lrc_en_q || lrc_zero);
  assign idle_sum = (byte_count_q != '0) ? idle_q + step_q : idle_q;

  always_comb begin
    byte_count_d = byte_count_q;
    idle_d       = idle_q;
    if (in_acc) begin
      if (req_type_i) begin
        if (idle_sum >= limit_q) begin
          byte_count_d = '0;
          idle_d       = '0;
        end else begin
          idle_d = idle_sum;
        end
      end else begin
        idle_d = '0;
        if (frame_done) begin
          byte_count_d = '0;
        end else begin
          byte_count_d = byte_count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      idle_q       <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      idle_q       <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc && !frame_done) begin
      store_q[byte_count_q] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (load) begin
      left_q <= cmd.echo ? 3'(scfr_pkg::FRAME_LEN) : 3'd1;
    end else if (out_acc) begin
      left_q <= left_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= cmd.kind;
      addr_q  <= cmd.addr;
      red_q   <= cmd.red;
      green_q <= cmd.green;
      blue_q  <= cmd.blue;
      // err bit forced in the first echo byte
      echo_q[0] <= cmd.echo ? (frame[0] | 8'h08) : 8'd0;
      for (int i = 1; i < scfr_pkg::FRAME_LEN; i++) begin
        echo_q[i] <= cmd.echo ? frame[i] : 8'd0;
      end
    end else if (out_acc) begin
      for (int i = 0; i < scfr_pkg::FRAME_LEN - 1; i++) begin
        echo_q[i] <= echo_q[i+1];
      end
      echo_q[scfr_pkg::FRAME_LEN-1] <= 8'd0;
    end
  end

  assign result_kind_o     = kind_q;
  assign channel_address_o = addr_q;
  assign red_value_o       = red_q;
  assign green_value_o     = green_q;
  assign blue_value_o      = blue_q;
  assign echo_byte_o       = echo_q[0];
  assign last_of_run_o     = (left_q == 3'd1);

  // assertions
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q != 3'd7)
    else $error("byte count out of range");

  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != scfr_pkg::KIND_ECHO) |-> last_of_run_o)
    else $error("command result not last of run");

  a_run_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q > 3'd1) |-> (kind_q == scfr_pkg::KIND_ECHO && addr_q == '0))
    else $error("multi-result run is not an echo");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !load) |=> $stable(left_q))
    else $error("result buffer changed while stalled");

endmodule
